### rtl/rlf_pkg.sv
// Shared types, constants and the color wheel lookup for the RGB LED fade controller.
package rlf_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int WHEEL_BITS = LEVEL_BITS + 3;
  localparam int TICK_BITS  = 16;

  localparam logic [LEVEL_BITS-1:0] LMAX       = {LEVEL_BITS{1'b1}};
  localparam logic [WHEEL_BITS-1:0] WHEEL_LAST = WHEEL_BITS'((6 << LEVEL_BITS) - 1);
  localparam logic [TICK_BITS-1:0]  TICKS_MAX  = {TICK_BITS{1'b1}};

  localparam logic [7:0] RAMP_PERIOD_RST = 8'd5;
  localparam logic [7:0] FADE_PERIOD_RST = 8'd10;

  // Configuration register indexes
  localparam logic [1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] CFG_RAMP_PERIOD = 2'd1;
  localparam logic [1:0] CFG_FADE_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_COLOR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_OFF  = 4'b0001,
    PH_UP   = 4'b0010,
    PH_LIT  = 4'b0100,
    PH_DOWN = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] r;
    logic [LEVEL_BITS-1:0] g;
    logic [LEVEL_BITS-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic       effect_mode;
    logic [7:0] ramp_period;
    logic [7:0] fade_period;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    rgb_t                  level;
    rgb_t                  target;
    logic [7:0]            ramp_ticks;
    logic [WHEEL_BITS-1:0] wheel_pos;
    logic [TICK_BITS-1:0]  wheel_ticks;
  } state_t;

  // Color at a wheel position: six segments, each sweeping one channel
  function automatic rgb_t wheel_color(input logic [WHEEL_BITS-1:0] pos);
    logic [2:0]            seg;
    logic [LEVEL_BITS-1:0] off;
    rgb_t                  c;
    seg = pos[WHEEL_BITS-1:LEVEL_BITS];
    off = pos[LEVEL_BITS-1:0];
    case (seg)
      3'd0:    c = '{r: LMAX,       g: off,        b: '0};
      3'd1:    c = '{r: LMAX - off, g: LMAX,       b: '0};
      3'd2:    c = '{r: '0,         g: LMAX,       b: off};
      3'd3:    c = '{r: '0,         g: LMAX - off, b: LMAX};
      3'd4:    c = '{r: off,        g: '0,         b: LMAX};
      default: c = '{r: LMAX,       g: '0,         b: LMAX - off};
    endcase
    return c;
  endfunction

endpackage

### rtl/rgb_led_fade_controller.sv
// Top level of the RGB LED soft-start and color wheel fade controller.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   op, red_in, green_in, blue_in
//   out      output     out_valid / out_stall red_duty, green_duty, blue_duty, lit, ramping
//   cfg      input      cfg_we (no wait)      cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result is registered into the result
// register, or into the skid entry while that register is held, from the single next-state update.
// A two-entry output buffer (result register plus skid) lets a transfer go in while
// a result waits; in_stall rises only when both entries are full.
// rst is synchronous: levels 0, targets full scale, LED off, out_valid low, config registers at defaults.
module rgb_led_fade_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_duty,
  output logic [7:0] green_duty,
  output logic [7:0] blue_duty,
  output logic       lit,
  output logic       ramping,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  typedef struct packed {
    rlf_pkg::rgb_t duty;
    logic          lit;
    logic          ramping;
  } result_t;

  rlf_pkg::cfg_t   cfg;
  rlf_pkg::state_t state;
  rlf_pkg::state_t state_next;
  rlf_pkg::rgb_t   color;
  result_t         res_next;
  result_t         out_res;
  result_t         skid_res;
  logic            skid_valid;
  logic            accept;
  logic            out_take;

  assign color    = '{r: red_in, g: green_in, b: blue_in};
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_mode <= 1'b0;
      cfg.ramp_period <= rlf_pkg::RAMP_PERIOD_RST;
      cfg.fade_period <= rlf_pkg::FADE_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlf_pkg::CFG_EFFECT_MODE: cfg.effect_mode <= cfg_data[0];
        rlf_pkg::CFG_RAMP_PERIOD: cfg.ramp_period <= cfg_data;
        rlf_pkg::CFG_FADE_PERIOD: cfg.fade_period <= cfg_data;
        default: ;
      endcase
    end
  end

  rlf_step u_step (
    .cur   (state),
    .cfg   (cfg),
    .op    (op),
    .color (color),
    .nxt   (state_next)
  );

  assign res_next.duty    = state_next.level;
  assign res_next.lit     = (state_next.phase == rlf_pkg::PH_LIT);
  assign res_next.ramping = (state_next.phase == rlf_pkg::PH_UP) ||
                            (state_next.phase == rlf_pkg::PH_DOWN);

  // Controller state: advance on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= rlf_pkg::PH_OFF;
      state.level       <= '0;
      state.target      <= '{r: rlf_pkg::LMAX, g: rlf_pkg::LMAX, b: rlf_pkg::LMAX};
      state.ramp_ticks  <= '0;
      state.wheel_pos   <= '0;
      state.wheel_ticks <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output buffer: result register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: load from skid or from the new transfer
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_res <= skid_res;
    end else if (accept) begin
      if (!out_valid || out_take) out_res <= res_next;
      else                        skid_res <= res_next;
    end
  end

  assign red_duty   = out_res.duty.r;
  assign green_duty = out_res.duty.g;
  assign blue_duty  = out_res.duty.b;
  assign lit        = out_res.lit;
  assign ramping    = out_res.ramping;

endmodule

### rtl/rlf_step.sv
// Next-state logic for one command or tick of the fade controller.
module rlf_step (
  input  rlf_pkg::state_t           cur,
  input  rlf_pkg::cfg_t             cfg,
  input  logic [1:0]                op,
  input  rlf_pkg::rgb_t             color,
  output rlf_pkg::state_t           nxt
);

  rlf_pkg::state_t s1;
  rlf_pkg::op_t    op_code;
  logic [7:0]      rt_inc;
  rlf_pkg::rgb_t   stepped;
  logic            fade_hit;

  assign op_code = rlf_pkg::op_t'(op);
  assign rt_inc  = cur.ramp_ticks + 8'd1;

  // One ramp step on every channel, up toward target or down toward zero
  always_comb begin
    stepped = cur.level;
    if (cur.phase == rlf_pkg::PH_UP) begin
      if (cur.level.r < cur.target.r) stepped.r = cur.level.r + 1'b1;
      if (cur.level.g < cur.target.g) stepped.g = cur.level.g + 1'b1;
      if (cur.level.b < cur.target.b) stepped.b = cur.level.b + 1'b1;
    end else begin
      if (cur.level.r != '0) stepped.r = cur.level.r - 1'b1;
      if (cur.level.g != '0) stepped.g = cur.level.g - 1'b1;
      if (cur.level.b != '0) stepped.b = cur.level.b - 1'b1;
    end
  end

  // Apply the command
  always_comb begin
    s1 = cur;
    case (op_code)
      rlf_pkg::OP_TICK: begin
        if (cur.wheel_ticks != rlf_pkg::TICKS_MAX) s1.wheel_ticks = cur.wheel_ticks + 1'b1;
        if (cur.phase == rlf_pkg::PH_UP || cur.phase == rlf_pkg::PH_DOWN) begin
          if (rt_inc < cfg.ramp_period) begin
            s1.ramp_ticks = rt_inc;
          end else begin
            s1.ramp_ticks = '0;
            s1.level      = stepped;
            if (cur.phase == rlf_pkg::PH_UP && stepped == cur.target)
              s1.phase = rlf_pkg::PH_LIT;
            else if (cur.phase == rlf_pkg::PH_DOWN && stepped == '0)
              s1.phase = rlf_pkg::PH_OFF;
          end
        end
      end
      rlf_pkg::OP_ON: begin
        if (cur.phase == rlf_pkg::PH_OFF) begin
          s1.level      = '0;
          s1.ramp_ticks = '0;
          s1.phase      = (cur.target == '0) ? rlf_pkg::PH_LIT : rlf_pkg::PH_UP;
        end
      end
      rlf_pkg::OP_OFF: begin
        if (cur.phase == rlf_pkg::PH_LIT) begin
          s1.ramp_ticks = '0;
          s1.phase      = (cur.level == '0) ? rlf_pkg::PH_OFF : rlf_pkg::PH_DOWN;
        end
      end
      rlf_pkg::OP_COLOR: begin
        if (cur.phase == rlf_pkg::PH_LIT) begin
          s1.target = color;
          s1.level  = color;
        end
      end
      default: s1 = cur;
    endcase
  end

  // Advance the color wheel once enough ticks have gone by while lit with effect_mode set
  assign fade_hit = (s1.phase == rlf_pkg::PH_LIT) && cfg.effect_mode &&
                    (s1.wheel_ticks > {8'd0, cfg.fade_period});

  always_comb begin
    nxt = s1;
    if (fade_hit) begin
      nxt.wheel_ticks = '0;
      nxt.target      = rlf_pkg::wheel_color(s1.wheel_pos);
      nxt.level       = rlf_pkg::wheel_color(s1.wheel_pos);
      nxt.wheel_pos   = (s1.wheel_pos == rlf_pkg::WHEEL_LAST) ? '0 : s1.wheel_pos + 1'b1;
    end
  end

endmodule
